// ----- design/pei_pkg.sv -----
// pei_pkg: shared types, register indexes and saturation helpers
// for the particle euler integrator; no dependencies
package pei_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DU_STEPS = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRAV_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAV_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REST_SPEED = 3'd6;

	typedef struct packed {
		logic command;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic [30:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} out_t;

	// request to the shared divide / square root unit
	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} du_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ovf;
	} du_stat_t;

	// signed result from a magnitude, saturated to 32 bits
	function automatic logic [31:0] sat_mag(input logic neg, input logic ovf,
			input logic [31:0] mag);
		logic [31:0] r;
		if (ovf) begin
			r = neg ? 32'h8000_0000 : 32'h7fff_ffff;
		end else if (neg) begin
			r = (mag > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag);
		end else begin
			r = mag[31] ? 32'h7fff_ffff : mag;
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		logic [31:0] r;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			r = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

// ----- design/pei_mul.sv -----
// pei_mul: registered 32 x 32 unsigned multiplier shared by the sequencer
// no dependencies
module pei_mul (
	input logic clk,
	input logic [31:0] a,
	input logic [31:0] b,
	output logic [63:0] p
);
	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;
endmodule

// ----- design/pei_divsqrt.sv -----
// pei_divsqrt: shared iterative unit, restoring divide 64/32 or 64-bit
// integer square root, one result bit per cycle; uses pei_pkg
module pei_divsqrt (
	input logic clk,
	input logic arst_n,
	input pei_pkg::du_ctl_t ctl,
	input logic [63:0] num,
	input logic [31:0] den,
	output pei_pkg::du_stat_t stat,
	output logic [31:0] res
);
	localparam int CNT_W = $clog2(pei_pkg::DU_STEPS);

	logic busy_q, done_q, ovf_q, mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [34:0] rem_q;
	logic [63:0] sh_q;
	logic [31:0] acc_q, den_q;
	logic [34:0] t, d;
	logic ge;

	always_comb begin
		if (mode_q) begin
			t = {rem_q[32:0], sh_q[63:62]};
			d = {1'b0, acc_q, 2'b01};
		end else begin
			t = {rem_q[33:0], sh_q[63]};
			d = {3'b000, den_q};
		end
		ge = (t >= d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(pei_pkg::DU_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.sqrt_mode;
			den_q <= den;
			acc_q <= '0;
			if (ctl.sqrt_mode) begin
				rem_q <= '0;
				sh_q <= num;
				ovf_q <= 1'b0;
			end else begin
				rem_q <= {3'b000, num[63:32]};
				sh_q <= {num[31:0], 32'd0};
				// quotient would not fit 32 bits
				ovf_q <= (num[63:32] >= den);
			end
		end else if (busy_q) begin
			rem_q <= ge ? (t - d) : t;
			acc_q <= {acc_q[30:0], ge};
			sh_q <= mode_q ? {sh_q[61:0], 2'b00} : {sh_q[62:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.ovf = ovf_q;
	assign res = acc_q;
endmodule

// ----- design/particle_euler_integrator_core.sv -----
// particle_euler_integrator_core: one particle, semi-implicit euler step in
// signed fixed point; uses pei_pkg, pei_mul, pei_divsqrt
//
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | pei_pkg::in_t (command, force xyz)
// out     | out | out_valid / out_ready| pei_pkg::out_t (position, velocity)
// cfg     | in  | cfg_we               | cfg_idx, cfg_data
//
// a force request runs three divides by mass, one per axis; a tick runs
// three such divides, two square roots and, when the speed limit applies,
// three divides by speed; the shared unit gives one result bit per cycle
// in_ready is high only while the sequencer is idle
// a finished result waits in the output register; a new request may be
// taken meanwhile, and its result waits until that register is free
module particle_euler_integrator_core #(
	parameter int FRAC_BITS = pei_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pei_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pei_pkg::out_t out_data,
	input logic cfg_we,
	input logic [pei_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [31:0] cfg_data
);
	localparam int unsigned ONE_I = 1 << FRAC_BITS;
	localparam logic [31:0] ONE_Q = 32'(ONE_I);
	localparam logic [31:0] MIN_Q = 32'(ONE_I / 100);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FDIV = 4'd1;
	localparam logic [3:0] S_FWAIT = 4'd2;
	localparam logic [3:0] S_VADD = 4'd3;
	localparam logic [3:0] S_SQ_MUL = 4'd4;
	localparam logic [3:0] S_SQ_ACC = 4'd5;
	localparam logic [3:0] S_SQRT_GO = 4'd6;
	localparam logic [3:0] S_SQRT_WAIT = 4'd7;
	localparam logic [3:0] S_LIM_MUL = 4'd8;
	localparam logic [3:0] S_LIM_DIV = 4'd9;
	localparam logic [3:0] S_LIM_WAIT = 4'd10;
	localparam logic [3:0] S_FR_MUL = 4'd11;
	localparam logic [3:0] S_FR_WR = 4'd12;
	localparam logic [3:0] S_POS = 4'd13;
	localparam logic [3:0] S_GND = 4'd14;
	localparam logic [3:0] S_OUT = 4'd15;

	logic [3:0] state_q;
	logic [1:0] idx_q;
	logic cmd_q, pass_q;
	logic [31:0] frc_q [3];
	logic [31:0] grav_q [3];
	logic [30:0] mass_q, maxsp_q, rest_q;
	logic [16:0] fric_q;
	logic [31:0] pos_q [3];
	logic [31:0] vel_q [3];
	logic [31:0] acc_q [3];
	logic [63:0] sum_q;
	logic [31:0] sp_q;
	logic out_valid_q;
	pei_pkg::out_t out_q;

	logic [31:0] cur_v, v_mag, src_f, f_mag, mass_eff, fr_eff, k_fr, thr;
	logic [31:0] mul_b, du_res, du_q, lim_q, fr_v;
	logic [63:0] mul_p, du_num;
	pei_pkg::du_ctl_t du_ctl;
	pei_pkg::du_stat_t du_stat;

	always_comb begin
		cur_v = vel_q[idx_q];
		v_mag = cur_v[31] ? (32'd0 - cur_v) : cur_v;
		src_f = cmd_q ? frc_q[idx_q] : grav_q[idx_q];
		f_mag = src_f[31] ? (32'd0 - src_f) : src_f;
		mass_eff = ({1'b0, mass_q} < MIN_Q) ? MIN_Q : {1'b0, mass_q};
		fr_eff = ({15'd0, fric_q} < MIN_Q) ? MIN_Q : {15'd0, fric_q};
		if (fr_eff > ONE_Q) begin
			fr_eff = ONE_Q;
		end
		k_fr = ONE_Q - fr_eff;
		thr = ({1'b0, rest_q} > MIN_Q) ? {1'b0, rest_q} : MIN_Q;

		case (state_q)
			S_LIM_MUL: mul_b = {1'b0, maxsp_q};
			S_FR_MUL: mul_b = k_fr;
			default: mul_b = v_mag;
		endcase

		du_ctl.start = (state_q == S_FDIV) || (state_q == S_SQRT_GO)
			|| (state_q == S_LIM_DIV);
		du_ctl.sqrt_mode = (state_q == S_SQRT_GO);
		case (state_q)
			S_SQRT_GO: du_num = sum_q;
			S_LIM_DIV: du_num = mul_p;
			default: du_num = 64'(f_mag) << FRAC_BITS;
		endcase

		du_q = pei_pkg::sat_mag(src_f[31], du_stat.ovf, du_res);
		lim_q = pei_pkg::sat_mag(cur_v[31], du_stat.ovf, du_res);
		fr_v = pei_pkg::sat_mag(cur_v[31], 1'b0, mul_p[FRAC_BITS +: 32]);
	end

	pei_mul u_mul (
		.clk(clk),
		.a(v_mag),
		.b(mul_b),
		.p(mul_p)
	);

	pei_divsqrt u_du (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(du_ctl),
		.num(du_num),
		.den((state_q == S_LIM_DIV) ? sp_q : mass_eff),
		.stat(du_stat),
		.res(du_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q[0] <= '0;
			grav_q[1] <= '0;
			grav_q[2] <= '0;
			mass_q <= 31'(ONE_I);
			fric_q <= 17'((ONE_I + 5) / 10);
			maxsp_q <= 31'(5 * ONE_I);
			rest_q <= 31'((ONE_I * 28 + 500) / 1000);
		end else if (cfg_we) begin
			case (cfg_idx)
				pei_pkg::REG_GRAV_X: grav_q[0] <= cfg_data;
				pei_pkg::REG_GRAV_Y: grav_q[1] <= cfg_data;
				pei_pkg::REG_GRAV_Z: grav_q[2] <= cfg_data;
				pei_pkg::REG_MASS: mass_q <= cfg_data[30:0];
				pei_pkg::REG_FRICTION: fric_q <= cfg_data[16:0];
				pei_pkg::REG_MAX_SPEED: maxsp_q <= cfg_data[30:0];
				pei_pkg::REG_REST_SPEED: rest_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			frc_q[0] <= in_data.force_x;
			frc_q[1] <= in_data.force_y;
			frc_q[2] <= in_data.force_z;
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.pos_x <= pos_q[0];
			out_q.pos_y <= pos_q[1][30:0];
			out_q.pos_z <= pos_q[2];
			out_q.vel_x <= vel_q[0];
			out_q.vel_y <= vel_q[1];
			out_q.vel_z <= vel_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			cmd_q <= 1'b0;
			pass_q <= 1'b0;
			sum_q <= '0;
			sp_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_data.command;
						idx_q <= '0;
						state_q <= S_FDIV;
					end
				end
				S_FDIV: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (du_stat.done) begin
						acc_q[idx_q] <= pei_pkg::sat_add(acc_q[idx_q], du_q);
						if (idx_q == 2'd2) begin
							idx_q <= '0;
							state_q <= cmd_q ? S_OUT : S_VADD;
						end else begin
							idx_q <= idx_q + 2'd1;
							state_q <= S_FDIV;
						end
					end
				end
				S_VADD: begin
					vel_q[idx_q] <= pei_pkg::sat_add(vel_q[idx_q], acc_q[idx_q]);
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						sum_q <= '0;
						pass_q <= 1'b0;
						state_q <= S_SQ_MUL;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				S_SQ_MUL: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					sum_q <= sum_q + mul_p;
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						state_q <= S_SQRT_GO;
					end else begin
						idx_q <= idx_q + 2'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_SQRT_GO: state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (du_stat.done) begin
						sp_q <= du_res;
						idx_q <= '0;
						if (!pass_q) begin
							state_q <= (du_res > {1'b0, maxsp_q}) ? S_LIM_MUL : S_FR_MUL;
						end else begin
							// slow particle comes to rest
							if (du_res < thr) begin
								for (int i = 0; i < 3; i++) begin
									vel_q[i] <= '0;
								end
							end
							state_q <= S_POS;
						end
					end
				end
				S_LIM_MUL: state_q <= S_LIM_DIV;
				S_LIM_DIV: state_q <= S_LIM_WAIT;
				S_LIM_WAIT: begin
					if (du_stat.done) begin
						vel_q[idx_q] <= lim_q;
						if (idx_q == 2'd2) begin
							idx_q <= '0;
							state_q <= S_FR_MUL;
						end else begin
							idx_q <= idx_q + 2'd1;
							state_q <= S_LIM_MUL;
						end
					end
				end
				S_FR_MUL: state_q <= S_FR_WR;
				S_FR_WR: begin
					vel_q[idx_q] <= fr_v;
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						sum_q <= '0;
						pass_q <= 1'b1;
						state_q <= S_SQ_MUL;
					end else begin
						idx_q <= idx_q + 2'd1;
						state_q <= S_FR_MUL;
					end
				end
				S_POS: begin
					pos_q[idx_q] <= pei_pkg::sat_add(pos_q[idx_q], vel_q[idx_q]);
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						state_q <= S_GND;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				S_GND: begin
					// ground plane at y = 0
					if (pos_q[1][31] || pos_q[1] == 32'd0) begin
						pos_q[1] <= '0;
						vel_q[1] <= '0;
					end
					for (int i = 0; i < 3; i++) begin
						acc_q[i] <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_FDIV))
		else $error("request accepted but sequencer did not start");

	a_du_not_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		du_ctl.start |-> !du_stat.busy)
		else $error("shared unit started while busy");

	a_pos_y_above_ground: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pos_q[1][31])
		else $error("position y below ground");

	a_ground_stops_y: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pos_q[1] != 32'd0 || vel_q[1] == 32'd0))
		else $error("y velocity left on ground");
endmodule

// ----- bench/particle_euler_integrator_core_tb.sv -----
// particle_euler_integrator_core_tb: drives force and tick requests through the core,
// predicts position and velocity per request and compares; depends on pei_pkg and the core
module particle_euler_integrator_core_tb;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_FORCE = 1'b1;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 110;

	class motion_scoreboard;
		localparam longint unsigned ONE = 64'd1 << pei_pkg::FRAC_BITS_DEF;
		localparam longint unsigned FLOOR_Q = ONE / 100;
		logic signed [31:0] grav[3];
		logic [30:0] mass;
		logic [16:0] fric;
		logic [30:0] vmax;
		logic [30:0] vrest;
		logic signed [31:0] pos[3];
		logic signed [31:0] vel[3];
		logic signed [31:0] acc[3];
		pei_pkg::out_t motion_q[$];
		int errors;

		function new();
			for (int i = 0; i < 3; i++) begin
				grav[i] = 0; pos[i] = 0; vel[i] = 0; acc[i] = 0;
			end
			mass = 31'd65536;
			fric = 17'd6554;
			vmax = 31'd327680;
			vrest = 31'd1835;
			errors = 0;
		endfunction

		function void set_reg(logic [pei_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				pei_pkg::REG_GRAV_X: grav[0] = data;
				pei_pkg::REG_GRAV_Y: grav[1] = data;
				pei_pkg::REG_GRAV_Z: grav[2] = data;
				pei_pkg::REG_MASS: mass = data[30:0];
				pei_pkg::REG_FRICTION: fric = data[16:0];
				pei_pkg::REG_MAX_SPEED: vmax = data[30:0];
				pei_pkg::REG_REST_SPEED: vrest = data[30:0];
				default: ;
			endcase
		endfunction

		function logic signed [31:0] clip32(longint v);
			logic signed [31:0] r;
			if (v > 64'sh7fff_ffff) r = 32'sh7fff_ffff;
			else if (v < -64'sh8000_0000) r = 32'sh8000_0000;
			else r = v[31:0];
			return r;
		endfunction

		// x * num / den, truncated toward zero
		function longint scale_trunc(longint x, longint unsigned num, longint unsigned den);
			longint unsigned mag;
			longint unsigned q;
			mag = (x < 0) ? longint'(-x) : longint'(x);
			q = mag * num / den;
			return (x < 0) ? -longint'(q) : longint'(q);
		endfunction

		function longint unsigned root64(longint unsigned n);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function longint unsigned speed();
			longint unsigned s;
			longint v;
			longint unsigned m;
			s = 0;
			for (int i = 0; i < 3; i++) begin
				v = vel[i];
				m = (v < 0) ? longint'(-v) : longint'(v);
				s += m * m;
			end
			return root64(s);
		endfunction

		function void push_force(logic signed [31:0] f, int i);
			longint unsigned m;
			longint fl;
			m = (mass < FLOOR_Q) ? FLOOR_Q : longint'(mass);
			fl = f;
			acc[i] = clip32(longint'(acc[i]) + clip32(scale_trunc(fl, ONE, m)));
		endfunction

		function void advance();
			longint unsigned sp;
			longint unsigned fr;
			longint unsigned thr;
			for (int i = 0; i < 3; i++) push_force(grav[i], i);
			for (int i = 0; i < 3; i++) vel[i] = clip32(longint'(vel[i]) + longint'(acc[i]));
			sp = speed();
			if (sp > vmax)
				for (int i = 0; i < 3; i++) vel[i] = clip32(scale_trunc(vel[i], vmax, sp));
			fr = (fric < FLOOR_Q) ? FLOOR_Q : longint'(fric);
			if (fr > ONE) fr = ONE;
			for (int i = 0; i < 3; i++) vel[i] = clip32(scale_trunc(vel[i], ONE - fr, ONE));
			thr = (vrest > FLOOR_Q) ? longint'(vrest) : FLOOR_Q;
			if (speed() < thr)
				for (int i = 0; i < 3; i++) vel[i] = 0;
			for (int i = 0; i < 3; i++) pos[i] = clip32(longint'(pos[i]) + longint'(vel[i]));
			if (pos[1] <= 0) begin
				pos[1] = 0;
				vel[1] = 0;
			end
			for (int i = 0; i < 3; i++) acc[i] = 0;
		endfunction

		function void note_request(pei_pkg::in_t req);
			pei_pkg::out_t e;
			if (req.command == CMD_FORCE) begin
				push_force(req.force_x, 0);
				push_force(req.force_y, 1);
				push_force(req.force_z, 2);
			end else begin
				advance();
			end
			e.pos_x = pos[0];
			e.pos_y = pos[1][30:0];
			e.pos_z = pos[2];
			e.vel_x = vel[0];
			e.vel_y = vel[1];
			e.vel_z = vel[2];
			motion_q.push_back(e);
		endfunction

		function void check_result(pei_pkg::out_t got);
			pei_pkg::out_t e;
			if (motion_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = motion_q.pop_front();
			if (got.pos_x !== e.pos_x || got.pos_y !== e.pos_y || got.pos_z !== e.pos_z ||
					got.vel_x !== e.vel_x || got.vel_y !== e.vel_y || got.vel_z !== e.vel_z) begin
				$display("%0t: mismatch expected pos %h %h %h vel %h %h %h", $time,
					e.pos_x, e.pos_y, e.pos_z, e.vel_x, e.vel_y, e.vel_z);
				$display("%0t:          actual   pos %h %h %h vel %h %h %h", $time,
					got.pos_x, got.pos_y, got.pos_z, got.vel_x, got.vel_y, got.vel_z);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pei_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	pei_pkg::out_t out_data;
	logic cfg_we;
	logic [pei_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [31:0] cfg_data;

	motion_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	particle_euler_integrator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// scoreboard taps and watchdog, sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			if (in_valid && in_ready) sb.note_request(in_data);
			if ((out_valid && out_ready) || (in_valid && in_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("particle_euler_integrator_core_tb: errors");
				$finish;
			end
		end
	end

	task automatic send_request(logic cmd, logic [31:0] fx, logic [31:0] fy, logic [31:0] fz);
		pei_pkg::in_t req;
		req.command = cmd;
		req.force_x = fx;
		req.force_y = fy;
		req.force_z = fz;
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		@(posedge clk);
		while (sb.motion_q.size() != 0) @(posedge clk);
	endtask

	// leaves the write enable high; the caller drops it after the last write
	task automatic write_reg(logic [pei_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_force();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = $urandom();
			3, 4: v = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
			default: v = $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
		endcase
		return v;
	endfunction

	task automatic apply_setting(int k);
		logic [31:0] g[3];
		case (k)
			1: begin
				g[0] = 32'h0000_2000; g[1] = -32'sd642252; g[2] = 0;
				write_reg(pei_pkg::REG_GRAV_X, g[0]);
				write_reg(pei_pkg::REG_GRAV_Y, g[1]);
				write_reg(pei_pkg::REG_GRAV_Z, g[2]);
				write_reg(pei_pkg::REG_MASS, 32'd131072);
				write_reg(pei_pkg::REG_FRICTION, 32'd6554);
				write_reg(pei_pkg::REG_MAX_SPEED, 32'd327680);
				write_reg(pei_pkg::REG_REST_SPEED, 32'd1835);
			end
			2: begin
				write_reg(pei_pkg::REG_GRAV_X, 32'h8000_0000);
				write_reg(pei_pkg::REG_GRAV_Y, 32'h7fff_ffff);
				write_reg(pei_pkg::REG_GRAV_Z, 32'h8000_0000);
				write_reg(pei_pkg::REG_MASS, 32'd0);
				write_reg(pei_pkg::REG_FRICTION, 32'd0);
				write_reg(pei_pkg::REG_MAX_SPEED, 32'h7fff_ffff);
				write_reg(pei_pkg::REG_REST_SPEED, 32'd0);
			end
			3: begin
				write_reg(pei_pkg::REG_GRAV_X, 32'h7fff_ffff);
				write_reg(pei_pkg::REG_GRAV_Y, 32'h8000_0000);
				write_reg(pei_pkg::REG_GRAV_Z, 32'h7fff_ffff);
				write_reg(pei_pkg::REG_MASS, 32'hffff_ffff);
				write_reg(pei_pkg::REG_FRICTION, 32'd65536);
				write_reg(pei_pkg::REG_MAX_SPEED, 32'd0);
				write_reg(pei_pkg::REG_REST_SPEED, 32'h7fff_ffff);
			end
			4: begin
				// friction above one and mass just under the floor
				write_reg(pei_pkg::REG_GRAV_X, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
				write_reg(pei_pkg::REG_GRAV_Y, 32'h0001_0000);
				write_reg(pei_pkg::REG_GRAV_Z, $urandom());
				write_reg(pei_pkg::REG_MASS, 32'd654);
				write_reg(pei_pkg::REG_FRICTION, 32'h0001_ffff);
				write_reg(pei_pkg::REG_MAX_SPEED, 32'd327680);
				write_reg(pei_pkg::REG_REST_SPEED, 32'd656);
			end
			default: begin
				for (int i = 0; i < 3; i++)
					g[i] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
				write_reg(pei_pkg::REG_GRAV_X, g[0]);
				write_reg(pei_pkg::REG_GRAV_Y, g[1]);
				write_reg(pei_pkg::REG_GRAV_Z, g[2]);
				write_reg(pei_pkg::REG_MASS, $urandom_range(1, 32'h0010_0000));
				write_reg(pei_pkg::REG_FRICTION, $urandom_range(0, 20000));
				write_reg(pei_pkg::REG_MAX_SPEED, $urandom_range(0, 32'h0040_0000));
				write_reg(pei_pkg::REG_REST_SPEED, $urandom_range(0, 5000));
			end
		endcase
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: force extremes, ticks on reset defaults, ground clamp
		send_request(CMD_TICK, 0, 0, 0);
		send_request(CMD_FORCE, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_TICK, 0, 0, 0);
		send_request(CMD_FORCE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		send_request(CMD_FORCE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_request(CMD_TICK, 0, 0, 0);
		send_request(CMD_FORCE, 32'h0000_0100, 32'h0000_0200, 32'hffff_ff00);
		send_request(CMD_TICK, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_request(CMD_FORCE, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_TICK, 0, 0, 0);
		send_request(CMD_FORCE, 32'h0002_0000, 32'hfffe_0000, 32'h0000_0000);
		for (int i = 0; i < 6; i++) send_request(CMD_TICK, 0, 0, 0);

		for (int k = 0; k < N_PHASES; k++) begin
			drain();
			send_idle_pct = 0;
			recv_stall_pct = 0;
			if (k != 0) begin
				apply_setting(k);
				cfg_we <= 1'b0;
			end
			case (k % 4)
				1: send_idle_pct = 74;
				2: recv_stall_pct = 74;
				3: begin
					send_idle_pct = 28;
					recv_stall_pct = 28;
				end
				default: ;
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (k == 1 && n == 50) drain();
				if ($urandom_range(0, 99) < 45)
					send_request(CMD_FORCE, rand_force(), rand_force(), rand_force());
				else
					send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
			end
		end

		drain();
		recv_stall_pct = 0;
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.motion_q.size() == 0) begin
			$display("particle_euler_integrator_core_tb: clean");
		end else begin
			$display("particle_euler_integrator_core_tb: errors");
		end
		$finish;
	end

endmodule

// ----- particle_euler_integrator_core.f -----
design/pei_pkg.sv
design/pei_mul.sv
design/pei_divsqrt.sv
design/particle_euler_integrator_core.sv
bench/particle_euler_integrator_core_tb.sv
